// File: rtl/core/irn_pkg.sv
// irn_pkg: shared types, letter codes and numeral pattern tables for the
// integer to Roman numeral unit. Depends on nothing; used by irn_front, irn_back and the top level.

package irn_pkg;

	typedef logic [3:0] digit_t;

	// Work item handed from the front to the back through the queue.
	// digits[3] is thousands, digits[0] is units.
	typedef struct packed {
		logic              err;
		digit_t [3:0]      digits;
	} irn_entry_t;

	// Which letter of a decade a pattern position uses.
	typedef enum logic [1:0] {
		SEL_ONE,
		SEL_FIVE,
		SEL_TEN
	} irn_sel_t;

	localparam logic [7:0] LETTER_I    = 8'h49;
	localparam logic [7:0] LETTER_V    = 8'h56;
	localparam logic [7:0] LETTER_X    = 8'h58;
	localparam logic [7:0] LETTER_L    = 8'h4C;
	localparam logic [7:0] LETTER_C    = 8'h43;
	localparam logic [7:0] LETTER_D    = 8'h44;
	localparam logic [7:0] LETTER_M    = 8'h4D;
	localparam logic [7:0] LETTER_NONE = 8'h00;

	localparam logic [11:0] VALUE_MAX = 12'd3999;

	// Number of letters a decimal digit expands to.
	function automatic logic [2:0] pat_len(input digit_t d);
		logic [2:0] n;
		case (d)
			4'd0: n = 3'd0;
			4'd1: n = 3'd1;
			4'd2: n = 3'd2;
			4'd3: n = 3'd3;
			4'd4: n = 3'd2;
			4'd5: n = 3'd1;
			4'd6: n = 3'd2;
			4'd7: n = 3'd3;
			4'd8: n = 3'd4;
			4'd9: n = 3'd2;
			default: n = 3'd0;
		endcase
		return n;
	endfunction

	// Letter kind at a position within a digit's pattern.
	function automatic irn_sel_t pat_sel(input digit_t d, input logic [1:0] pos);
		irn_sel_t s;
		case (d)
			4'd4: s = (pos == 2'd0) ? SEL_ONE : SEL_FIVE;
			4'd9: s = (pos == 2'd0) ? SEL_ONE : SEL_TEN;
			4'd5, 4'd6, 4'd7, 4'd8: s = (pos == 2'd0) ? SEL_FIVE : SEL_ONE;
			default: s = SEL_ONE;
		endcase
		return s;
	endfunction

	// ASCII letter for a decade and letter kind.
	function automatic logic [7:0] decade_letter(input logic [1:0] dec, input irn_sel_t s);
		logic [7:0] l;
		l = LETTER_NONE;
		case (dec)
			2'd0: begin
				case (s)
					SEL_ONE:  l = LETTER_I;
					SEL_FIVE: l = LETTER_V;
					SEL_TEN:  l = LETTER_X;
					default:  l = LETTER_NONE;
				endcase
			end
			2'd1: begin
				case (s)
					SEL_ONE:  l = LETTER_X;
					SEL_FIVE: l = LETTER_L;
					SEL_TEN:  l = LETTER_C;
					default:  l = LETTER_NONE;
				endcase
			end
			2'd2: begin
				case (s)
					SEL_ONE:  l = LETTER_C;
					SEL_FIVE: l = LETTER_D;
					SEL_TEN:  l = LETTER_M;
					default:  l = LETTER_NONE;
				endcase
			end
			2'd3: begin
				case (s)
					SEL_ONE: l = LETTER_M;
					default: l = LETTER_NONE;
				endcase
			end
			default: l = LETTER_NONE;
		endcase
		return l;
	endfunction

endpackage

// File: rtl/core/irn_front.sv
// irn_front: three-stage classifier that checks the range of a value and
// splits it into decimal digits by constant compares. Depends on irn_pkg.

module irn_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [11:0]           value,
	output logic                  out_valid,
	input  logic                  out_ready,
	output irn_pkg::irn_entry_t   out_entry
);

	logic                 v_s1, v_s2, v_s3;
	logic                 err_s1, err_s2, err_s3;
	irn_pkg::digit_t      th_s1, th_s2, th_s3;
	irn_pkg::digit_t      hu_s2, hu_s3;
	irn_pkg::digit_t      tn_s3, un_s3;
	logic [9:0]           rem_s1;
	logic [6:0]           rem_s2;

	logic                 adv1, adv2, adv3;

	// Stage 1 inputs: range check and thousands.
	logic                 err_c;
	irn_pkg::digit_t      th_c;
	logic [11:0]          base_th_c;
	logic [11:0]          rem_th_c;

	// Stage 2 inputs: hundreds.
	irn_pkg::digit_t      hu_c;
	logic [9:0]           base_hu_c;
	logic [9:0]           rem_hu_c;

	// Stage 3 inputs: tens and units.
	irn_pkg::digit_t      tn_c;
	logic [6:0]           base_tn_c;
	logic [6:0]           rem_tn_c;

	assign adv3 = !v_s3 || out_ready;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign full = !adv1;

	always_comb begin
		err_c = (value == 12'd0) || (value > irn_pkg::VALUE_MAX);
		if (value >= 12'd3000) begin
			th_c      = 4'd3;
			base_th_c = 12'd3000;
		end else if (value >= 12'd2000) begin
			th_c      = 4'd2;
			base_th_c = 12'd2000;
		end else if (value >= 12'd1000) begin
			th_c      = 4'd1;
			base_th_c = 12'd1000;
		end else begin
			th_c      = 4'd0;
			base_th_c = 12'd0;
		end
		rem_th_c = value - base_th_c;
	end

	always_comb begin
		hu_c      = 4'd0;
		base_hu_c = 10'd0;
		for (int k = 1; k < 10; k++) begin
			if (rem_s1 >= 10'(k * 100)) begin
				hu_c      = 4'(k);
				base_hu_c = 10'(k * 100);
			end
		end
		rem_hu_c = rem_s1 - base_hu_c;
	end

	always_comb begin
		tn_c      = 4'd0;
		base_tn_c = 7'd0;
		for (int k = 1; k < 10; k++) begin
			if (rem_s2 >= 7'(k * 10)) begin
				tn_c      = 4'(k);
				base_tn_c = 7'(k * 10);
			end
		end
		rem_tn_c = rem_s2 - base_tn_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= push;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
			if (adv3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && push) begin
			err_s1 <= err_c;
			th_s1  <= th_c;
			rem_s1 <= rem_th_c[9:0];
		end
		if (adv2 && v_s1) begin
			err_s2 <= err_s1;
			th_s2  <= th_s1;
			hu_s2  <= hu_c;
			rem_s2 <= rem_hu_c[6:0];
		end
		if (adv3 && v_s2) begin
			err_s3 <= err_s2;
			th_s3  <= th_s2;
			hu_s3  <= hu_s2;
			tn_s3  <= tn_c;
			un_s3  <= rem_tn_c[3:0];
		end
	end

	assign out_valid        = v_s3;
	assign out_entry.err    = err_s3;
	assign out_entry.digits = {th_s3, hu_s3, tn_s3, un_s3};

endmodule

// File: rtl/core/irn_queue.sv
// irn_queue: short register-based queue that decouples the classifier from
// the letter sequencer. Depends on nothing.

module irn_queue #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr, do_rd;

	assign wr_ready = (count_q != CNT_W'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;
	assign rd_data  = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (do_rd) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// File: rtl/core/irn_back.sv
// irn_back: letter sequencer that walks the digit patterns of one entry and
// emits one letter per beat into an output register. Depends on irn_pkg.

module irn_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  irn_pkg::irn_entry_t   in_entry,
	output logic                  empty,
	input  logic                  pop,
	output logic [7:0]            letter,
	output logic                  last,
	output logic                  error
);

	logic                 busy_q;
	irn_pkg::irn_entry_t  ent_q;
	logic [1:0]           dec_q;
	logic [1:0]           pos_q;

	logic                 out_valid_q;
	logic [7:0]           letter_q;
	logic                 last_q;
	logic                 error_q;

	logic                 out_free, emit, load;
	irn_pkg::digit_t      cur_digit;
	logic [2:0]           cur_len;
	logic                 digit_end, lower_zero, cur_last;
	logic [1:0]           next_dec;
	logic [1:0]           load_dec;
	logic [7:0]           cur_letter;

	assign cur_digit  = ent_q.digits[dec_q];
	assign cur_len    = irn_pkg::pat_len(cur_digit);
	assign digit_end  = ({1'b0, pos_q} == cur_len - 3'd1);
	assign cur_letter = ent_q.err ? irn_pkg::LETTER_NONE :
		irn_pkg::decade_letter(dec_q, irn_pkg::pat_sel(cur_digit, pos_q));

	// Find the next nonzero decade below the current one.
	always_comb begin
		lower_zero = 1'b1;
		next_dec   = 2'd0;
		for (int j = 0; j < 4; j++) begin
			if ((2'(j) < dec_q) && (ent_q.digits[j] != 4'd0)) begin
				lower_zero = 1'b0;
				next_dec   = 2'(j);
			end
		end
	end

	// Highest nonzero decade of an incoming entry.
	always_comb begin
		load_dec = 2'd0;
		for (int j = 0; j < 4; j++) begin
			if (in_entry.digits[j] != 4'd0) begin
				load_dec = 2'(j);
			end
		end
	end

	assign cur_last = ent_q.err || (digit_end && lower_zero);
	assign out_free = !out_valid_q || pop;
	assign emit     = busy_q && out_free;
	assign load     = in_valid && (!busy_q || (emit && cur_last));
	assign in_ready = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
			end else if (emit && cur_last) begin
				busy_q <= 1'b0;
			end
			if (out_free) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ent_q <= in_entry;
			dec_q <= load_dec;
			pos_q <= 2'd0;
		end else if (emit) begin
			if (digit_end) begin
				dec_q <= next_dec;
				pos_q <= 2'd0;
			end else begin
				pos_q <= pos_q + 2'd1;
			end
		end
		if (emit) begin
			letter_q <= cur_letter;
			last_q   <= cur_last;
			error_q  <= ent_q.err;
		end
	end

	assign empty  = !out_valid_q;
	assign letter = letter_q;
	assign last   = last_q;
	assign error  = error_q;

endmodule

// File: rtl/core/integer_to_roman_numeral_unit.sv
// integer_to_roman_numeral_unit: top level of the binary to Roman numeral
// converter. Depends on irn_pkg, irn_front, irn_queue and irn_back.
//
// Push a 12-bit binary value while full is low; the unit returns its Roman
// numeral one ASCII letter per beat (I V X L C D M), most significant decade
// first, with last set on the final letter. A value of zero or above 3999
// returns a single beat with letter 0 and both error and last set. Results
// wait in an output register until popped, so the input side keeps taking
// values while a letter sits unclaimed, until the queue and front fill. The
// front classifies a value in three pipeline stages (range check and
// thousands, hundreds, tens and units) and accepts one value per cycle while
// full is low; a queue of QUEUE_DEPTH entries follows it. The back sequencer
// then walks the letters of each value in turn, holding while a letter waits
// unpopped, so the sustained rate is set by that sequencer and by the output
// letters. A pushed value passes the three front stages, the queue and the
// back before its first letter appears. No clearing pass follows reset.

module integer_to_roman_numeral_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [11:0] value,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  letter,
	output logic        last,
	output logic        error
);

	localparam int ENTRY_W = $bits(irn_pkg::irn_entry_t);

	// Front to queue beat.
	logic                 fq_valid, fq_ready;
	irn_pkg::irn_entry_t  fq_entry;

	// Queue to back beat.
	logic                 qb_valid, qb_ready;
	irn_pkg::irn_entry_t  qb_entry;
	logic [ENTRY_W-1:0]   qb_bits;

	// Classify: range check and digit split.
	irn_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.value     (value),
		.out_valid (fq_valid),
		.out_ready (fq_ready),
		.out_entry (fq_entry)
	);

	// Hold classified entries so front and back stall independently.
	irn_queue #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fq_valid),
		.wr_ready (fq_ready),
		.wr_data  (fq_entry),
		.rd_valid (qb_valid),
		.rd_ready (qb_ready),
		.rd_data  (qb_bits)
	);

	assign qb_entry = irn_pkg::irn_entry_t'(qb_bits);

	// Advance through the letters of each entry, one per beat.
	irn_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (qb_valid),
		.in_ready (qb_ready),
		.in_entry (qb_entry),
		.empty    (empty),
		.pop      (pop),
		.letter   (letter),
		.last     (last),
		.error    (error)
	);

endmodule
